// ===== rtl/tpd_pkg.sv =====
// Shared types and constants for the tree path distance engine.
package tpd_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = 10;
  localparam int CNT_W     = 11;
  localparam int WT_W      = 16;
  localparam int DIST_W    = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [NODE_W-1:0] MAX_EDGES = NODE_W'(MAX_NODES - 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_ROOT_NODE  = 2'd1,
    CFG_SPARE_2    = 2'd2,
    CFG_SPARE_3    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_ROOT,
    ST_POP,
    ST_POPW,
    ST_PDEP,
    ST_ERD,
    ST_ECHK,
    ST_EVIS,
    ST_QA,
    ST_QB,
    ST_QCHK,
    ST_QSTEP,
    ST_QCAP,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic [NODE_W-1:0] end_a;
    logic [NODE_W-1:0] end_b;
    logic [WT_W-1:0]   wt;
  } edge_t;

  typedef struct packed {
    logic              reached;
    logic [NODE_W-1:0] depth;
    logic [NODE_W-1:0] parent;
    logic [WT_W-1:0]   wt;
  } pent_t;

endpackage

// ===== rtl/tpd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
module tpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/tree_path_distance_engine.sv =====
// Top level of the tree path distance engine: control sequencer and memories.
//
// Channel   Direction  Handshake              Beat contents
// in        input      in_valid_i/in_stall_o  opcode, node_a, node_b, edge_weight
// out       output     out_valid_o/out_stall_i distance, status
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index, cfg_data
//
// One item is worked on at a time; in_stall_o is high while the sequencer is busy.
// A load is done at accept. A build runs a clearing pass of the parent memory, seeds
// the root, then for every node popped off the queue does pop, queue read, parent read
// and end-of-scan check, plus a read and a check per stored edge (and a visit for an edge
// touching the popped node), and ends on a pop that finds the queue empty. A query reads
// both parent entries, then lifts a node per tree edge on the path; self pairs and unreached
// nodes stop at the check; a range or not-built error caught at accept goes to output.
// Reset clears only control state; the memories need no clearing since a build
// always sweeps the parent memory before use. A stalled result holds the
// sequencer in its output state until the previous beat leaves.
module tree_path_distance_engine import tpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [NODE_W-1:0]    node_a_i,
  input  logic [NODE_W-1:0]    node_b_i,
  input  logic [WT_W-1:0]      edge_weight_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DIST_W-1:0]    distance_o,
  output logic                 status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  st_e state_q, state_d;

  logic [CNT_W-1:0]  node_count_q, node_count_d;
  logic [NODE_W-1:0] root_q, root_d;
  logic              built_q, built_d;
  logic [NODE_W-1:0] edge_count_q, edge_count_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  tail_q, tail_d;
  logic [NODE_W-1:0] u_q, u_d;
  logic [NODE_W-1:0] du_q, du_d;
  logic [NODE_W-1:0] v_q, v_d;
  logic [WT_W-1:0]   w_q, w_d;

  logic [NODE_W-1:0] cur_a_q, cur_a_d, cur_b_q, cur_b_d;
  logic [NODE_W-1:0] da_q, da_d, db_q, db_d;
  logic [NODE_W-1:0] pa_q, pa_d, pb_q, pb_d;
  logic [WT_W-1:0]   wa_q, wa_d, wb_q, wb_d;
  logic              ra_q, ra_d;
  logic              side_q, side_d;
  logic [DIST_W-1:0] sum_q, sum_d;
  logic [DIST_W-1:0] res_dist_q, res_dist_d;
  logic              res_stat_q, res_stat_d;

  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic              out_stat_q, out_stat_d;

  // memory ports
  logic              e_we;
  logic [NODE_W-1:0] e_waddr, e_raddr;
  edge_t             e_wdata, e_rdata;
  logic              p_we;
  logic [NODE_W-1:0] p_waddr, p_raddr;
  pent_t             p_wdata, p_rdata;
  logic              q_we;
  logic [NODE_W-1:0] q_waddr, q_raddr, q_rdata, q_wdata;

  logic [CNT_W-1:0]  n_use;
  logic              in_acc;
  logic              q_err;
  logic              e_hit;
  logic [NODE_W-1:0] e_other;
  logic              out_free;

  assign n_use    = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign q_err    = !built_q || ({1'b0, node_a_i} >= n_use) || ({1'b0, node_b_i} >= n_use);
  assign e_hit    = ({1'b0, e_rdata.end_a} < n_use) && ({1'b0, e_rdata.end_b} < n_use)
                 && ((e_rdata.end_a == u_q) || (e_rdata.end_b == u_q));
  assign e_other  = (e_rdata.end_a == u_q) ? e_rdata.end_b : e_rdata.end_a;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign status_o    = out_stat_q;

  tpd_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_NODES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  tpd_ram #(.WIDTH($bits(pent_t)), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  tpd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_BUILD) begin
            state_d = ST_CLR;
          end else if (opcode_i == OP_QUERY) begin
            state_d = q_err ? ST_OUT : ST_QA;
          end
        end
      end
      ST_CLR: begin
        if (cnt_q == CNT_W'(MAX_NODES - 1)) begin
          state_d = ({1'b0, root_q} < n_use) ? ST_ROOT : ST_IDLE;
        end
      end
      ST_ROOT: state_d = ST_POP;
      ST_POP:  state_d = (head_q == tail_q) ? ST_IDLE : ST_POPW;
      ST_POPW: state_d = ST_PDEP;
      ST_PDEP: state_d = ST_ERD;
      ST_ERD:  state_d = (cnt_q == {1'b0, edge_count_q}) ? ST_POP : ST_ECHK;
      ST_ECHK: state_d = e_hit ? ST_EVIS : ST_ERD;
      ST_EVIS: state_d = ST_ERD;
      ST_QA:   state_d = ST_QB;
      ST_QB:   state_d = ST_QCHK;
      ST_QCHK: begin
        if (!ra_q || !p_rdata.reached || (cur_a_q == cur_b_q)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_QSTEP;
        end
      end
      ST_QSTEP: state_d = (cur_a_q == cur_b_q) ? ST_OUT : ST_QCAP;
      ST_QCAP:  state_d = ST_QSTEP;
      ST_OUT:   state_d = out_free ? ST_IDLE : ST_OUT;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and registers' next values.
  always_comb begin
    node_count_d = node_count_q;
    root_d       = root_q;
    built_d      = built_q;
    edge_count_d = edge_count_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    tail_d       = tail_q;
    u_d          = u_q;
    du_d         = du_q;
    v_d          = v_q;
    w_d          = w_q;
    cur_a_d      = cur_a_q;
    cur_b_d      = cur_b_q;
    da_d         = da_q;
    db_d         = db_q;
    pa_d         = pa_q;
    pb_d         = pb_q;
    wa_d         = wa_q;
    wb_d         = wb_q;
    ra_d         = ra_q;
    side_d       = side_q;
    sum_d        = sum_q;
    res_dist_d   = res_dist_q;
    res_stat_d   = res_stat_q;
    out_valid_d  = out_valid_q;
    out_dist_d   = out_dist_q;
    out_stat_d   = out_stat_q;

    e_we    = 1'b0;
    e_waddr = edge_count_q;
    e_wdata = '{end_a: node_a_i, end_b: node_b_i, wt: edge_weight_i};
    e_raddr = cnt_q[NODE_W-1:0];
    p_we    = 1'b0;
    p_waddr = cnt_q[NODE_W-1:0];
    p_wdata = '0;
    p_raddr = cur_a_q;
    q_we    = 1'b0;
    q_waddr = tail_q[NODE_W-1:0];
    q_wdata = v_q;
    q_raddr = head_q[NODE_W-1:0];

    // Drop the output beat once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Register writes; a write to the node count or the root invalidates the tree.
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_NODE_COUNT) begin
        node_count_d = cfg_data_i;
        built_d      = 1'b0;
      end else if (cfg_index_i == CFG_ROOT_NODE) begin
        root_d  = cfg_data_i[NODE_W-1:0];
        built_d = 1'b0;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_LOAD) begin
            if (edge_count_q != MAX_EDGES) begin
              e_we         = 1'b1;
              edge_count_d = edge_count_q + NODE_W'(1);
            end
            built_d = 1'b0;
          end else if (opcode_i == OP_BUILD) begin
            built_d = 1'b0;
            cnt_d   = '0;
          end else if (opcode_i == OP_QUERY) begin
            cur_a_d    = node_a_i;
            cur_b_d    = node_b_i;
            res_dist_d = '0;
            res_stat_d = 1'b1;
          end
        end
      end
      ST_CLR: begin
        // Sweep the parent memory so no node reads as reached.
        p_we    = 1'b1;
        p_waddr = cnt_q[NODE_W-1:0];
        p_wdata = '0;
        cnt_d   = cnt_q + CNT_W'(1);
      end
      ST_ROOT: begin
        p_we    = 1'b1;
        p_waddr = root_q;
        p_wdata = '{reached: 1'b1, depth: '0, parent: root_q, wt: '0};
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = root_q;
        head_d  = '0;
        tail_d  = CNT_W'(1);
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
        end else begin
          q_raddr = head_q[NODE_W-1:0];
          head_d  = head_q + CNT_W'(1);
        end
      end
      ST_POPW: begin
        u_d     = q_rdata;
        p_raddr = q_rdata;
      end
      ST_PDEP: begin
        du_d  = p_rdata.depth;
        cnt_d = '0;
      end
      ST_ERD: begin
        e_raddr = cnt_q[NODE_W-1:0];
      end
      ST_ECHK: begin
        if (e_hit) begin
          p_raddr = e_other;
          v_d     = e_other;
          w_d     = e_rdata.wt;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_EVIS: begin
        // Link the neighbor at its first discovery and enqueue it.
        if (!p_rdata.reached) begin
          p_we    = 1'b1;
          p_waddr = v_q;
          p_wdata = '{reached: 1'b1, depth: du_q + NODE_W'(1), parent: u_q, wt: w_q};
          if (tail_q < CNT_W'(MAX_NODES)) begin
            q_we    = 1'b1;
            q_waddr = tail_q[NODE_W-1:0];
            q_wdata = v_q;
            tail_d  = tail_q + CNT_W'(1);
          end
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      ST_QA: begin
        p_raddr = cur_a_q;
      end
      ST_QB: begin
        ra_d    = p_rdata.reached;
        da_d    = p_rdata.depth;
        pa_d    = p_rdata.parent;
        wa_d    = p_rdata.wt;
        p_raddr = cur_b_q;
      end
      ST_QCHK: begin
        db_d  = p_rdata.depth;
        pb_d  = p_rdata.parent;
        wb_d  = p_rdata.wt;
        sum_d = '0;
        if (!ra_q || !p_rdata.reached) begin
          res_dist_d = '0;
          res_stat_d = 1'b1;
        end else begin
          res_dist_d = '0;
          res_stat_d = 1'b0;
        end
      end
      ST_QSTEP: begin
        // Lift the deeper node (node a on a tie) until both meet.
        if (cur_a_q == cur_b_q) begin
          res_dist_d = sum_q;
          res_stat_d = 1'b0;
        end else if (da_q >= db_q) begin
          sum_d   = sum_q + DIST_W'(wa_q);
          cur_a_d = pa_q;
          p_raddr = pa_q;
          side_d  = 1'b0;
        end else begin
          sum_d   = sum_q + DIST_W'(wb_q);
          cur_b_d = pb_q;
          p_raddr = pb_q;
          side_d  = 1'b1;
        end
      end
      ST_QCAP: begin
        if (side_q) begin
          db_d = p_rdata.depth;
          pb_d = p_rdata.parent;
          wb_d = p_rdata.wt;
        end else begin
          da_d = p_rdata.depth;
          pa_d = p_rdata.parent;
          wa_d = p_rdata.wt;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dist_d  = res_dist_q;
          out_stat_d  = res_stat_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= CNT_W'(2);
      root_q       <= '0;
      built_q      <= 1'b0;
      edge_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      root_q       <= root_d;
      built_q      <= built_d;
      edge_count_q <= edge_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    head_q     <= head_d;
    tail_q     <= tail_d;
    u_q        <= u_d;
    du_q       <= du_d;
    v_q        <= v_d;
    w_q        <= w_d;
    cur_a_q    <= cur_a_d;
    cur_b_q    <= cur_b_d;
    da_q       <= da_d;
    db_q       <= db_d;
    pa_q       <= pa_d;
    pb_q       <= pb_d;
    wa_q       <= wa_d;
    wb_q       <= wb_d;
    ra_q       <= ra_d;
    side_q     <= side_d;
    sum_q      <= sum_d;
    res_dist_q <= res_dist_d;
    res_stat_q <= res_stat_d;
    out_dist_q <= out_dist_d;
    out_stat_q <= out_stat_d;
  end

endmodule

// ===== test/tpd_checker.sv =====
// Channel monitor, distance predictor and result scoreboard for the tree path distance engine.
module tpd_checker import tpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [1:0]           opcode_i,
  input  logic [NODE_W-1:0]    node_a_i,
  input  logic [NODE_W-1:0]    node_b_i,
  input  logic [WT_W-1:0]      edge_weight_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [DIST_W-1:0]    distance_i,
  input  logic                 status_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIST_W-1:0] span;
    logic              err;
  } answer_t;

  logic [CNT_W-1:0]  node_cnt;
  logic [NODE_W-1:0] root_sel;
  logic [NODE_W-1:0] store_a [MAX_NODES-1];
  logic [NODE_W-1:0] store_b [MAX_NODES-1];
  logic [WT_W-1:0]   store_w [MAX_NODES-1];
  int unsigned       store_cnt;
  logic [NODE_W-1:0] up_node [MAX_NODES];
  logic [WT_W-1:0]   up_wt   [MAX_NODES];
  logic [MAX_NODES-1:0] reached;
  logic              tree_ok;
  answer_t           answers_q [$];

  initial fail_count_o = 0;

  function automatic int unsigned nodes_in_use();
    return (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
  endfunction

  // Breadth-first rooting over the stored edges, first discovery wins.
  task automatic root_tree();
    int unsigned nn;
    int unsigned head;
    logic [NODE_W-1:0] u, x, y, v;
    logic [NODE_W-1:0] frontier [$];
    tree_ok = 1'b0;
    reached = '0;
    nn = nodes_in_use();
    if (root_sel >= nn) return;
    reached[root_sel] = 1'b1;
    up_node[root_sel] = root_sel;
    up_wt[root_sel]   = '0;
    frontier.push_back(root_sel);
    head = 0;
    while (head < frontier.size()) begin
      u = frontier[head];
      head++;
      for (int e = 0; e < store_cnt; e++) begin
        x = store_a[e];
        y = store_b[e];
        if (x >= nn || y >= nn) continue;
        if (x == u) v = y;
        else if (y == u) v = x;
        else continue;
        if (reached[v]) continue;
        reached[v] = 1'b1;
        up_node[v] = u;
        up_wt[v]   = store_w[e];
        if (frontier.size() < MAX_NODES) frontier.push_back(v);
      end
    end
    tree_ok = 1'b1;
  endtask

  function automatic answer_t path_distance(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    int unsigned nn;
    int unsigned total;
    logic [NODE_W-1:0] x, meet;
    logic [MAX_NODES-1:0] marks;
    answer_t ans;
    nn = nodes_in_use();
    ans.span = '0;
    ans.err  = 1'b1;
    if (!tree_ok || a >= nn || b >= nn || !reached[a] || !reached[b]) return ans;
    ans.err = 1'b0;
    if (a == b) return ans;
    marks = '0;
    total = 0;
    x = a;
    marks[x] = 1'b1;
    for (int s = 0; x != root_sel && s < MAX_NODES; s++) begin
      x = up_node[x];
      marks[x] = 1'b1;
    end
    x = b;
    for (int s = 0; !marks[x] && s < MAX_NODES; s++) begin
      total += up_wt[x];
      x = up_node[x];
    end
    meet = x;
    x = a;
    for (int s = 0; x != meet && s < MAX_NODES; s++) begin
      total += up_wt[x];
      x = up_node[x];
    end
    ans.span = total[DIST_W-1:0];
    return ans;
  endfunction

  task automatic flag(string what);
    if (fail_count_o < 10) $display("[%0t] mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      node_cnt  = CNT_W'(2);
      root_sel  = '0;
      store_cnt = 0;
      reached   = '0;
      tree_ok   = 1'b0;
      answers_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          flag($sformatf("unexpected result distance=%0d status=%0d", distance_i, status_i));
        end else begin
          want = answers_q.pop_front();
          if (distance_i !== want.span)
            flag($sformatf("distance expected %0d got %0d", want.span, distance_i));
          if (status_i !== want.err)
            flag($sformatf("status expected %0d got %0d", want.err, status_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_NODE_COUNT: begin
            node_cnt = cfg_data_i;
            tree_ok  = 1'b0;
          end
          CFG_ROOT_NODE: begin
            root_sel = cfg_data_i[NODE_W-1:0];
            tree_ok  = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_e'(opcode_i))
          OP_LOAD: begin
            if (store_cnt < MAX_NODES - 1) begin
              store_a[store_cnt] = node_a_i;
              store_b[store_cnt] = node_b_i;
              store_w[store_cnt] = edge_weight_i;
              store_cnt++;
            end
            tree_ok = 1'b0;
          end
          OP_BUILD: root_tree();
          OP_QUERY: answers_q.push_back(path_distance(node_a_i, node_b_i));
          default: ;
        endcase
      end
      pending_o <= answers_q.size();
    end
  end

endmodule

// ===== test/tb_tree_path_distance_engine.sv =====
// Stimulus, clock, reset and verdict for the tree path distance engine testbench.
module tb_tree_path_distance_engine;
  import tpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no beat on any channel before the run is declared hung. The slowest
  // build here roots a few dozen nodes over a few hundred stored edges.
  localparam int HANG_LIMIT = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           opcode = OP_NONE;
  logic [NODE_W-1:0]    node_a = '0;
  logic [NODE_W-1:0]    node_b = '0;
  logic [WT_W-1:0]      edge_weight = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DIST_W-1:0]    distance;
  logic                 status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NODE_COUNT;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int items_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  always #10 clk_i = ~clk_i;

  tree_path_distance_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .node_a_i      (node_a),
    .node_b_i      (node_b),
    .edge_weight_i (edge_weight),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .distance_o    (distance),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  tpd_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .opcode_i      (opcode),
    .node_a_i      (node_a),
    .node_b_i      (node_b),
    .edge_weight_i (edge_weight),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .distance_i    (distance),
    .status_i      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver back-pressure: random stall bursts of random length, none once quiet.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Hang detection: count cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < HANG_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Present one input beat and return at the edge that accepts it. Valid stays high
  // afterwards; the next call either replaces the payload or opens a gap first.
  task automatic send_item(input op_e op, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic [WT_W-1:0] w);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    = 1'b1;
    opcode      = op;
    node_a      = a;
    node_b      = b;
    edge_weight = w;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  // Drop valid and hold until every answer is back and the engine has gone idle.
  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DAT_W'(value);
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [WT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return WT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] pick_node(input int unsigned lo, input int unsigned hi);
    return NODE_W'($urandom_range(lo, hi));
  endfunction

  // One phase: configure, load a spanning tree (random, chain or star shaped) with
  // some stray edges, build, then mostly in-range queries with some noise mixed in.
  task automatic tree_phase();
    int unsigned n, root, shape, p, r, nq;
    logic [NODE_W-1:0] x, y;
    n     = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(2, 24);
    root  = ($urandom_range(0, 9) == 0) ? $urandom_range(n, 1023) : $urandom_range(0, n - 1);
    shape = $urandom_range(0, 2);
    settle();
    write_reg(CFG_NODE_COUNT, n);
    write_reg(CFG_ROOT_NODE, root);
    for (int unsigned v = 1; v < n; v++) begin
      p = (shape == 0) ? $urandom_range(0, v - 1) : (shape == 1) ? v - 1 : 0;
      if ($urandom_range(0, 1)) send_item(OP_LOAD, NODE_W'(v), NODE_W'(p), pick_weight());
      else send_item(OP_LOAD, NODE_W'(p), NODE_W'(v), pick_weight());
      if ($urandom_range(0, 7) == 0)
        send_item(OP_LOAD, pick_node(0, 1023), pick_node(0, 1023), pick_weight());
    end
    send_item(OP_BUILD, pick_node(0, 1023), pick_node(0, 1023), pick_weight());
    nq = $urandom_range(6, 14);
    repeat (nq) begin
      r = $urandom_range(0, 19);
      x = pick_node(0, n - 1);
      y = pick_node(0, n - 1);
      if (r == 0) begin
        send_item(OP_NONE, pick_node(0, 1023), pick_node(0, 1023), pick_weight());
      end else if (r == 1) begin
        // A late load tears the tree down; rebuild half the time.
        send_item(OP_LOAD, x, y, pick_weight());
        if ($urandom_range(0, 1))
          send_item(OP_BUILD, x, y, pick_weight());
      end else if (r == 2) begin
        send_item(OP_QUERY, pick_node(0, 1023), pick_node(0, 1023), pick_weight());
      end else begin
        send_item(OP_QUERY, x, y, pick_weight());
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset defaults, query before build, trivial tree of a lone root.
    send_item(OP_QUERY, 10'd0, 10'd1, 16'd0);
    send_item(OP_BUILD, 10'd0, 10'd0, 16'd0);
    send_item(OP_QUERY, 10'd0, 10'd0, 16'hFFFF);
    send_item(OP_QUERY, 10'd0, 10'd1, 16'd0);
    send_item(OP_QUERY, 10'd1023, 10'd0, 16'd0);

    // Full node range rooted at the top node; parallel edge and self loop.
    settle();
    write_reg(CFG_NODE_COUNT, MAX_NODES);
    write_reg(CFG_ROOT_NODE, 1023);
    send_item(OP_LOAD, 10'd1023, 10'd0, 16'hFFFF);
    send_item(OP_LOAD, 10'd0, 10'd1023, 16'd1);
    send_item(OP_LOAD, 10'd0, 10'd0, 16'd7);
    send_item(OP_LOAD, 10'd1, 10'd0, 16'd0);
    send_item(OP_LOAD, 10'd2, 10'd1, 16'h5555);
    send_item(OP_LOAD, 10'd3, 10'd2, 16'hAAAA);
    send_item(OP_BUILD, 10'd0, 10'd0, 16'd0);
    send_item(OP_QUERY, 10'd1023, 10'd3, 16'd0);
    send_item(OP_QUERY, 10'd3, 10'd1023, 16'd0);
    send_item(OP_QUERY, 10'd1023, 10'd1023, 16'd0);
    send_item(OP_QUERY, 10'd2, 10'd700, 16'd0);
    send_item(OP_NONE, 10'd1023, 10'd1023, 16'hFFFF);
    send_item(OP_QUERY, 10'd3, 10'd1, 16'd0);

    // Spare register indexes leave the built tree alone; a load clears it.
    settle();
    write_reg(CFG_SPARE_2, 5);
    write_reg(CFG_SPARE_3, 2047);
    send_item(OP_QUERY, 10'd1, 10'd2, 16'd0);
    send_item(OP_LOAD, 10'd4, 10'd3, 16'd100);
    send_item(OP_QUERY, 10'd4, 10'd3, 16'd0);

    // Oversized node count saturates; then a root beyond the node count.
    settle();
    write_reg(CFG_NODE_COUNT, 2047);
    write_reg(CFG_ROOT_NODE, 0);
    send_item(OP_BUILD, 10'd0, 10'd0, 16'd0);
    send_item(OP_QUERY, 10'd4, 10'd1023, 16'd0);
    settle();
    write_reg(CFG_NODE_COUNT, 4);
    write_reg(CFG_ROOT_NODE, 1000);
    send_item(OP_BUILD, 10'd0, 10'd0, 16'd0);
    send_item(OP_QUERY, 10'd0, 10'd1, 16'd0);

    // Random phases with bursty idling on both sides.
    while (items_sent < 530) tree_phase();

    // Last part, no idling: a burst of back to back loads, then use them.
    settle();
    quiet = 1'b1;
    write_reg(CFG_NODE_COUNT, 2);
    write_reg(CFG_ROOT_NODE, 0);
    repeat (16)
      send_item(OP_LOAD, pick_node(0, 1023), pick_node(0, 1023), pick_weight());
    settle();
    write_reg(CFG_NODE_COUNT, 6);
    write_reg(CFG_ROOT_NODE, $urandom_range(0, 5));
    send_item(OP_BUILD, 10'd0, 10'd0, 16'd0);
    send_item(OP_LOAD, 10'd1, 10'd2, 16'd9);
    send_item(OP_QUERY, 10'd0, 10'd1, 16'd0);
    send_item(OP_BUILD, 10'd0, 10'd0, 16'd0);
    repeat (10) send_item(OP_QUERY, pick_node(0, 5), pick_node(0, 5), 16'd0);

    settle();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tpd_pkg.sv
rtl/tpd_ram.sv
rtl/tree_path_distance_engine.sv
test/tpd_checker.sv
test/tb_tree_path_distance_engine.sv
